### hdl/sif_pkg.sv
// sif_pkg: shared types, constants and defaults for the sorted interval overlap flagger
// no dependencies
`timescale 1ns / 1ps

package sif_pkg;

  localparam int DefQueueDepth = 8;
  localparam int DefChromBits = 10;
  localparam int ChromFieldW = 10;
  localparam int PosW = 32;
  localparam int WideW = PosW + 2;
  localparam int ClassW = 3;
  localparam int TagW = 32;
  localparam int FlagW = 3;
  localparam int FrontDepth = 2;
  localparam int OutDepth = 4;

  localparam logic [FlagW-1:0] FlgNone = 3'b000;
  localparam logic [FlagW-1:0] FlgDiff = 3'b001;
  localparam logic [FlagW-1:0] FlgClus = 3'b010;
  localparam logic [FlagW-1:0] FlgSame = 3'b100;

  localparam logic ModeInterval = 1'b0;
  localparam logic ModeFlush = 1'b1;

  typedef struct packed {
    logic                   mode;
    logic [ChromFieldW-1:0] chrom_id;
    logic [PosW-1:0]        start_pos;
    logic [PosW-1:0]        end_pos;
    logic [ClassW-1:0]      var_class;
    logic [TagW-1:0]        item_tag;
  } in_t;

  typedef struct packed {
    logic [TagW-1:0]        out_tag;
    logic [ChromFieldW-1:0] out_chrom;
    logic [PosW-1:0]        out_start;
    logic [PosW-1:0]        out_end;
    logic [ClassW-1:0]      out_class;
    logic                   flag_diff_class;
    logic                   flag_cluster_error;
    logic                   flag_same_class;
    logic                   flag_overflow;
    logic                   last;
  } out_t;

  // classified request handed from front to engine
  typedef struct packed {
    logic                   flush;
    logic [ChromFieldW-1:0] chrom;
    logic [PosW-1:0]        start_pos;
    logic [PosW-1:0]        end_pos;
    logic [ClassW-1:0]      var_class;
    logic [TagW-1:0]        item_tag;
    logic                   ins;
    logic [WideW-1:0]       ws;
    logic [WideW-1:0]       we;
  } cls_item_t;

endpackage

### hdl/sorted_interval_overlap_flagger.sv
// sorted_interval_overlap_flagger: top level, front queue, engine and result queue
// depends on sif_pkg, sif_front, sif_engine, sif_outq
//
//   channel   handshake      payload   accepted when
//   request   push / full    item      push && !full
//   result    empty / pop    result    pop && !empty
//
// a request is registered into the front queue; the engine then emits its results and
// closes with the append, or on a flush with the check that finds the queue empty;
// the result queue registers each result before it shows; unless that queue is full,
// the engine retires one queue entry per cycle through its single head port
// rst is synchronous; it clears queue counts and pointers, not entry storage
// a full result queue stalls the engine, and a busy engine backs up the front queue
`timescale 1ns / 1ps

module sorted_interval_overlap_flagger import sif_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int CHROM_BITS  = DefChromBits
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);

  cls_item_t head;
  logic      avail;
  logic      take;
  logic      room;
  logic      wr;
  out_t      wdata;

  sif_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .avail (avail),
    .take  (take),
    .head  (head)
  );

  sif_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CHROM_BITS  (CHROM_BITS)
  ) u_engine (
    .clk   (clk),
    .rst   (rst),
    .avail (avail),
    .nxt   (head),
    .take  (take),
    .room  (room),
    .wr    (wr),
    .wdata (wdata)
  );

  sif_outq u_outq (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .wdata  (wdata),
    .room   (room),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

### hdl/sif_front.sv
// sif_front: accepts requests, classifies them (flush, insertion, widened span)
// and holds them in a short queue for the engine; depends on sif_pkg
`timescale 1ns / 1ps

module sif_front import sif_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_t       item,
  output logic      avail,
  input  logic      take,
  output cls_item_t head
);

  localparam int PtrW = $clog2(FrontDepth);
  localparam int CntW = $clog2(FrontDepth + 1);

  cls_item_t            slots [FrontDepth];
  cls_item_t            cls;
  logic [PtrW-1:0]      wr_ptr;
  logic [PtrW-1:0]      rd_ptr;
  logic [CntW-1:0]      cnt;
  logic                 do_wr;
  logic                 do_rd;

  always_comb begin
    cls.flush     = (item.mode == ModeFlush);
    cls.chrom     = item.chrom_id;
    cls.start_pos = item.start_pos;
    cls.end_pos   = item.end_pos;
    cls.var_class = item.var_class;
    cls.item_tag  = item.item_tag;
    cls.ins       = (item.start_pos == item.end_pos);
    // insertions widen by one on each side
    cls.ws        = WideW'(item.start_pos) - WideW'(cls.ins);
    cls.we        = WideW'(item.end_pos) + WideW'(cls.ins);
  end

  assign full  = (cnt == CntW'(FrontDepth));
  assign avail = (cnt != '0);
  assign head  = slots[rd_ptr];
  assign do_wr = push && !full;
  assign do_rd = take && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + PtrW'(1);
      if (do_rd) rd_ptr <= rd_ptr + PtrW'(1);
      if (do_wr && !do_rd) cnt <= cnt + CntW'(1);
      else if (do_rd && !do_wr) cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= cls;
  end

endmodule

### hdl/sif_engine.sv
// sif_engine: interval queue, head retirement, append and parallel overlap compare
// depends on sif_pkg
`timescale 1ns / 1ps

module sif_engine import sif_pkg::*; #(
  parameter int QUEUE_DEPTH = DefQueueDepth,
  parameter int CHROM_BITS  = DefChromBits
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      avail,
  input  cls_item_t nxt,
  output logic      take,
  input  logic      room,
  output logic      wr,
  output out_t      wdata
);

  localparam int CntW   = $clog2(QUEUE_DEPTH + 1);
  localparam int ChromW = (CHROM_BITS < ChromFieldW) ? CHROM_BITS : ChromFieldW;

  cls_item_t          cur;
  logic               cur_valid;
  logic [CntW-1:0]    count;
  logic               ovf_done;

  logic [ChromW-1:0]  e_chrom [QUEUE_DEPTH];
  logic [PosW-1:0]    e_start [QUEUE_DEPTH];
  logic [PosW-1:0]    e_end   [QUEUE_DEPTH];
  logic [ClassW-1:0]  e_class [QUEUE_DEPTH];
  logic [TagW-1:0]    e_tag   [QUEUE_DEPTH];
  logic [FlagW-1:0]   e_flags [QUEUE_DEPTH];
  logic               e_ins   [QUEUE_DEPTH];
  logic [WideW-1:0]   e_ws    [QUEUE_DEPTH];
  logic [WideW-1:0]   e_we    [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] ovl;
  logic [FlagW-1:0]       fl [QUEUE_DEPTH];
  logic [FlagW-1:0]       new_flags;
  logic                   emit;
  logic                   ovf;
  logic                   lst;
  logic                   do_pop;
  logic                   do_app;
  logic                   done;

  // one overlap lane per queue entry
  always_comb begin
    logic lane_v;
    logic span_hit;
    new_flags = FlgNone;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      lane_v = (CntW'(i) < count);
      if (e_ins[i] && cur.ins) begin
        span_hit = (e_start[i] == cur.start_pos);
      end else begin
        span_hit = ($signed(e_ws[i]) < $signed(cur.we)) &&
                   ($signed(cur.ws) < $signed(e_we[i]));
      end
      ovl[i] = lane_v && (e_chrom[i] == cur.chrom[ChromW-1:0]) && span_hit;
      if (!ovl[i]) begin
        fl[i] = FlgNone;
      end else if (e_class[i] != cur.var_class) begin
        fl[i] = FlgDiff;
      end else if (e_start[i] == cur.start_pos && e_end[i] == cur.end_pos) begin
        fl[i] = FlgClus;
      end else begin
        fl[i] = FlgSame;
      end
      new_flags = new_flags | fl[i];
    end
  end

  always_comb begin
    emit   = 1'b0;
    ovf    = 1'b0;
    lst    = 1'b0;
    do_app = 1'b0;
    done   = 1'b0;
    if (cur_valid) begin
      if (cur.flush) begin
        if (count == '0) begin
          done = 1'b1;
        end else begin
          emit = 1'b1;
          lst  = (count == CntW'(1));
        end
      end else if (ovf_done) begin
        // forced-out head already gone, append without another retire pass
        do_app = 1'b1;
        done   = 1'b1;
      end else if (count != '0 && !ovl[0]) begin
        emit = 1'b1;
        lst  = (count == CntW'(1)) || ovl[1];
      end else if (count == CntW'(QUEUE_DEPTH)) begin
        emit = 1'b1;
        ovf  = 1'b1;
        lst  = 1'b1;
      end else begin
        do_app = 1'b1;
        done   = 1'b1;
      end
    end
    do_pop = emit && room;
    wr     = do_pop;
    take   = avail && (!cur_valid || done);
  end

  always_comb begin
    wdata.out_tag            = e_tag[0];
    wdata.out_chrom          = ChromFieldW'(e_chrom[0]);
    wdata.out_start          = e_start[0];
    wdata.out_end            = e_end[0];
    wdata.out_class          = e_class[0];
    wdata.flag_diff_class    = |(e_flags[0] & FlgDiff);
    wdata.flag_cluster_error = |(e_flags[0] & FlgClus);
    wdata.flag_same_class    = |(e_flags[0] & FlgSame);
    wdata.flag_overflow      = ovf;
    wdata.last               = lst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      count     <= '0;
      ovf_done  <= 1'b0;
    end else begin
      if (take) cur_valid <= 1'b1;
      else if (done) cur_valid <= 1'b0;
      if (do_pop) count <= count - CntW'(1);
      else if (do_app) count <= count + CntW'(1);
      if (done) ovf_done <= 1'b0;
      else if (do_pop && ovf) ovf_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= nxt;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          e_chrom[i] <= e_chrom[i+1];
          e_start[i] <= e_start[i+1];
          e_end[i]   <= e_end[i+1];
          e_class[i] <= e_class[i+1];
          e_tag[i]   <= e_tag[i+1];
          e_flags[i] <= e_flags[i+1];
          e_ins[i]   <= e_ins[i+1];
          e_ws[i]    <= e_ws[i+1];
          e_we[i]    <= e_we[i+1];
        end
      end else if (do_app) begin
        if (CntW'(i) == count) begin
          e_chrom[i] <= cur.chrom[ChromW-1:0];
          e_start[i] <= cur.start_pos;
          e_end[i]   <= cur.end_pos;
          e_class[i] <= cur.var_class;
          e_tag[i]   <= cur.item_tag;
          e_flags[i] <= new_flags;
          e_ins[i]   <= cur.ins;
          e_ws[i]    <= cur.ws;
          e_we[i]    <= cur.we;
        end else begin
          e_flags[i] <= e_flags[i] | fl[i];
        end
      end
    end
  end

endmodule

### hdl/sif_outq.sv
// sif_outq: result queue between the engine and the result port
// depends on sif_pkg
`timescale 1ns / 1ps

module sif_outq import sif_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  out_t wdata,
  output logic room,
  output logic empty,
  input  logic pop,
  output out_t result
);

  localparam int PtrW = $clog2(OutDepth);
  localparam int CntW = $clog2(OutDepth + 1);

  out_t            slots [OutDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] cnt;
  logic            do_wr;
  logic            do_rd;

  assign room   = (cnt != CntW'(OutDepth));
  assign empty  = (cnt == '0);
  assign result = slots[rd_ptr];
  assign do_wr  = wr && room;
  assign do_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + PtrW'(1);
      if (do_rd) rd_ptr <= rd_ptr + PtrW'(1);
      if (do_wr && !do_rd) cnt <= cnt + CntW'(1);
      else if (do_rd && !do_wr) cnt <= cnt - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wdata;
  end

endmodule

### hdl/sif_checker.sv
// sif_checker: port-level assertions for the flagger, bound to the top level
// depends on sif_pkg and sorted_interval_overlap_flagger
`timescale 1ns / 1ps

module sif_checker import sif_pkg::*; (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input in_t  item,
  input logic empty,
  input logic pop,
  input out_t result
);

  a_reset_state: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_ovf_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.flag_overflow) |-> result.last)
    else $error("overflow result not marked last");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(result))
    else $error("waiting result changed");

  a_hold_empty: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

endmodule

bind sorted_interval_overlap_flagger sif_checker u_chk (.*);
